// ===== hdl/mos_pkg.sv =====
// Shared types, constants and the opcode decoder of the 6502 instruction executor.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mos_pkg;

    // Memory geometry
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // Reset values
    localparam logic [15:0] START_RST  = 16'h0600;
    localparam logic [15:0] RAND_RST   = 16'h00FE;
    localparam logic [7:0]  SP_RST     = 8'hFF;
    localparam logic [7:0]  STACK_PAGE = 8'h01;

    // Configuration register indexes
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] CFG_START = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_RAND  = 1'b1;

    // Host operation codes
    localparam logic [1:0] HOP_WRITE   = 2'd0;
    localparam logic [1:0] HOP_READ    = 2'd1;
    localparam logic [1:0] HOP_EXEC    = 2'd2;
    localparam logic [1:0] HOP_RESTART = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_BRK = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // Flag bit positions in NV1BDIZC
    localparam int F_N = 7;
    localparam int F_V = 6;
    localparam int F_B = 4;
    localparam int F_D = 3;
    localparam int F_I = 2;
    localparam int F_Z = 1;
    localparam int F_C = 0;
    localparam logic [7:0] P_ONE  = 8'h20;
    localparam logic [7:0] P_PULL = 8'hDF;

    // Opcodes handled one by one
    localparam logic [7:0] OP_INX = 8'hE8, OP_INY = 8'hC8, OP_DEX = 8'hCA, OP_DEY = 8'h88;
    localparam logic [7:0] OP_CLC = 8'h18, OP_CLI = 8'h58, OP_CLD = 8'hD8, OP_CLV = 8'hB8;
    localparam logic [7:0] OP_SEC = 8'h38, OP_SEI = 8'h78, OP_SED = 8'hF8;
    localparam logic [7:0] OP_TAX = 8'hAA, OP_TXA = 8'h8A, OP_TAY = 8'hA8, OP_TYA = 8'h98;
    localparam logic [7:0] OP_TSX = 8'hBA, OP_TXS = 8'h9A;
    localparam logic [7:0] OP_PHA = 8'h48, OP_PHP = 8'h08, OP_PLA = 8'h68, OP_PLP = 8'h28;
    localparam logic [7:0] OP_BRK = 8'h00, OP_RTI = 8'h40, OP_NOP = 8'hEA;
    localparam logic [7:0] OP_BPL = 8'h10, OP_BMI = 8'h30, OP_BVC = 8'h50, OP_BVS = 8'h70;
    localparam logic [7:0] OP_BCC = 8'h90, OP_BCS = 8'hB0, OP_BNE = 8'hD0, OP_BEQ = 8'hF0;
    localparam logic [7:0] OP_JMP = 8'h4C, OP_JMPI = 8'h6C, OP_JSR = 8'h20, OP_RTS = 8'h60;
    localparam logic [7:0] OP_STA_IMM = 8'h89;

    typedef enum logic [3:0] {
        M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY
    } t_mode;

    typedef enum logic [4:0] {
        K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC,
        K_ASL, K_ROL, K_LSR, K_ROR, K_DEC, K_INC,
        K_LDX, K_LDY, K_STX, K_STY, K_CPX, K_CPY, K_BIT
    } t_kind;

    typedef enum logic [3:0] {
        CL_BAD, CL_IMPL, CL_PUSH, CL_PULL, CL_BRANCH,
        CL_JMP, CL_JMPI, CL_JSR, CL_RTS, CL_MEM
    } t_class;

    typedef struct packed {
        t_class cls;
        t_mode  mode;
        t_kind  kind;
    } t_dec;

    // Datapath step commands
    typedef enum logic [4:0] {
        ACT_NONE, ACT_CLEAR, ACT_HOSTWR, ACT_HOSTRD, ACT_RDLAT, ACT_RESTART, ACT_RANDWR,
        ACT_F0, ACT_F1, ACT_F2, ACT_F3, ACT_DEC, ACT_P1, ACT_P2, ACT_RDEA, ACT_DATA,
        ACT_PLD, ACT_JSR2, ACT_RTS1, ACT_RTS2
    } t_act;

    typedef struct packed {
        t_act act;
        logic accept;
    } t_cmd;

    typedef struct packed {
        t_dec dec;
        logic halted;
        logic clear_done;
    } t_sts;

    function automatic logic is_store(input t_kind k);
        return (k == K_STA) || (k == K_STX) || (k == K_STY);
    endfunction

    function automatic logic is_ptr_mode(input t_mode m);
        return (m == M_INDX) || (m == M_INDY);
    endfunction

    // Decode an opcode into class, addressing mode and operation kind
    function automatic t_dec decode(input logic [7:0] op);
        t_dec d;
        logic [2:0] aaa;
        logic [2:0] bbb;
        logic [1:0] cc;
        aaa = op[7:5];
        bbb = op[4:2];
        cc  = op[1:0];
        d.cls  = CL_MEM;
        d.mode = M_IMP;
        d.kind = K_ORA;
        unique case (op) inside
            OP_INX, OP_INY, OP_DEX, OP_DEY, OP_CLC, OP_CLI, OP_CLD, OP_CLV,
            OP_SEC, OP_SEI, OP_SED, OP_TAX, OP_TXA, OP_TAY, OP_TYA, OP_TSX,
            OP_TXS, OP_BRK, OP_RTI, OP_NOP: d.cls = CL_IMPL;
            OP_PHA, OP_PHP: d.cls = CL_PUSH;
            OP_PLA, OP_PLP: d.cls = CL_PULL;
            OP_BPL, OP_BMI, OP_BVC, OP_BVS,
            OP_BCC, OP_BCS, OP_BNE, OP_BEQ: d.cls = CL_BRANCH;
            OP_JMP:  d.cls = CL_JMP;
            OP_JMPI: d.cls = CL_JMPI;
            OP_JSR:  d.cls = CL_JSR;
            OP_RTS:  d.cls = CL_RTS;
            // index register loads, stores, compares and BIT
            8'hA2: begin d.kind = K_LDX; d.mode = M_IMM;  end
            8'hA6: begin d.kind = K_LDX; d.mode = M_ZP;   end
            8'hB6: begin d.kind = K_LDX; d.mode = M_ZPY;  end
            8'hAE: begin d.kind = K_LDX; d.mode = M_ABS;  end
            8'hBE: begin d.kind = K_LDX; d.mode = M_ABSY; end
            8'hA0: begin d.kind = K_LDY; d.mode = M_IMM;  end
            8'hA4: begin d.kind = K_LDY; d.mode = M_ZP;   end
            8'hB4: begin d.kind = K_LDY; d.mode = M_ZPX;  end
            8'hAC: begin d.kind = K_LDY; d.mode = M_ABS;  end
            8'hBC: begin d.kind = K_LDY; d.mode = M_ABSX; end
            8'h86: begin d.kind = K_STX; d.mode = M_ZP;   end
            8'h96: begin d.kind = K_STX; d.mode = M_ZPY;  end
            8'h8E: begin d.kind = K_STX; d.mode = M_ABS;  end
            8'h84: begin d.kind = K_STY; d.mode = M_ZP;   end
            8'h94: begin d.kind = K_STY; d.mode = M_ZPX;  end
            8'h8C: begin d.kind = K_STY; d.mode = M_ABS;  end
            8'hE0: begin d.kind = K_CPX; d.mode = M_IMM;  end
            8'hE4: begin d.kind = K_CPX; d.mode = M_ZP;   end
            8'hEC: begin d.kind = K_CPX; d.mode = M_ABS;  end
            8'hC0: begin d.kind = K_CPY; d.mode = M_IMM;  end
            8'hC4: begin d.kind = K_CPY; d.mode = M_ZP;   end
            8'hCC: begin d.kind = K_CPY; d.mode = M_ABS;  end
            8'h24: begin d.kind = K_BIT; d.mode = M_ZP;   end
            8'h2C: begin d.kind = K_BIT; d.mode = M_ABS;  end
            default: begin
                if (cc == 2'd1 && op != OP_STA_IMM) begin
                    // accumulator group: kind follows aaa directly
                    d.kind = t_kind'({2'b00, aaa});
                    unique case (bbb)
                        3'd0: d.mode = M_INDX;
                        3'd1: d.mode = M_ZP;
                        3'd2: d.mode = M_IMM;
                        3'd3: d.mode = M_ABS;
                        3'd4: d.mode = M_INDY;
                        3'd5: d.mode = M_ZPX;
                        3'd6: d.mode = M_ABSY;
                        default: d.mode = M_ABSX;
                    endcase
                end else if (cc == 2'd2 && (aaa <= 3'd3 || aaa >= 3'd6) && bbb[0]) begin
                    // read-modify-write group on memory
                    unique case (aaa)
                        3'd0: d.kind = K_ASL;
                        3'd1: d.kind = K_ROL;
                        3'd2: d.kind = K_LSR;
                        3'd3: d.kind = K_ROR;
                        3'd6: d.kind = K_DEC;
                        default: d.kind = K_INC;
                    endcase
                    unique case (bbb)
                        3'd1: d.mode = M_ZP;
                        3'd3: d.mode = M_ABS;
                        3'd5: d.mode = M_ZPX;
                        default: d.mode = M_ABSX;
                    endcase
                end else if (cc == 2'd2 && aaa <= 3'd3 && bbb == 3'd2) begin
                    d.kind = t_kind'(5'(K_ASL) + {2'b00, aaa});
                    d.mode = M_ACC;
                end else begin
                    d.cls = CL_BAD;
                end
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mos_req_if.sv =====
// Request channel of the 6502 instruction executor: valid/ready plus the host operation.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface mos_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  random_byte;

    modport source (output valid, operation, address, write_data, random_byte, input ready);
    modport sink   (input valid, operation, address, write_data, random_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/mos_rsp_if.sv =====
// Result channel of the 6502 instruction executor: valid/ready plus the register snapshot.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface mos_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  read_data;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_pointer;
    logic [15:0] program_counter;
    logic [7:0]  status_flags;

    modport source (output valid, status, read_data, accumulator, index_x, index_y,
                    stack_pointer, program_counter, status_flags, input ready);
    modport sink   (input valid, status, read_data, accumulator, index_x, index_y,
                    stack_pointer, program_counter, status_flags, output ready);
endinterface

`default_nettype wire

// ===== hdl/mos_ctrl.sv =====
// Sequencer of the 6502 executor: walks each execute request through fetch, address and data steps.
// Depends on mos_pkg for the step commands and decode status.
`timescale 1ns / 1ps
`default_nettype none

module mos_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic [1:0]     i_operation,
    input  wire logic           i_out_ready,
    input  wire mos_pkg::t_sts  i_sts,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output mos_pkg::t_cmd       o_cmd
);

    typedef enum logic [16:0] {
        S_CLEAR = 17'h00001,
        S_IDLE  = 17'h00002,
        S_RDLAT = 17'h00004,
        S_F0    = 17'h00008,
        S_F1    = 17'h00010,
        S_F2    = 17'h00020,
        S_F3    = 17'h00040,
        S_DEC   = 17'h00080,
        S_P1    = 17'h00100,
        S_P2    = 17'h00200,
        S_RDEA  = 17'h00400,
        S_DATA  = 17'h00800,
        S_PLD   = 17'h01000,
        S_JSR2  = 17'h02000,
        S_RTS1  = 17'h04000,
        S_RTS2  = 17'h08000,
        S_RESP  = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);

    // Next state and datapath command
    always_comb begin
        n_state      = r_state;
        o_cmd.act    = mos_pkg::ACT_NONE;
        o_cmd.accept = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.act = mos_pkg::ACT_CLEAR;
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_operation)
                        mos_pkg::HOP_WRITE: begin
                            o_cmd.act = mos_pkg::ACT_HOSTWR;
                            n_state   = S_RESP;
                        end
                        mos_pkg::HOP_READ: begin
                            o_cmd.act = mos_pkg::ACT_HOSTRD;
                            n_state   = S_RDLAT;
                        end
                        mos_pkg::HOP_EXEC: begin
                            if (i_sts.halted) begin
                                n_state = S_RESP;
                            end else begin
                                o_cmd.act = mos_pkg::ACT_RANDWR;
                                n_state   = S_F0;
                            end
                        end
                        default: begin
                            o_cmd.act = mos_pkg::ACT_RESTART;
                            n_state   = S_RESP;
                        end
                    endcase
                end
            end
            S_RDLAT: begin
                o_cmd.act = mos_pkg::ACT_RDLAT;
                n_state   = S_RESP;
            end
            S_F0: begin o_cmd.act = mos_pkg::ACT_F0; n_state = S_F1; end
            S_F1: begin o_cmd.act = mos_pkg::ACT_F1; n_state = S_F2; end
            S_F2: begin o_cmd.act = mos_pkg::ACT_F2; n_state = S_F3; end
            S_F3: begin o_cmd.act = mos_pkg::ACT_F3; n_state = S_DEC; end
            S_DEC: begin
                o_cmd.act = mos_pkg::ACT_DEC;
                unique case (i_sts.dec.cls)
                    mos_pkg::CL_JMPI: n_state = S_P1;
                    mos_pkg::CL_MEM:
                        n_state = mos_pkg::is_ptr_mode(i_sts.dec.mode) ? S_P1 : S_RDEA;
                    mos_pkg::CL_PULL: n_state = S_PLD;
                    mos_pkg::CL_JSR:  n_state = S_JSR2;
                    mos_pkg::CL_RTS:  n_state = S_RTS1;
                    default:          n_state = S_RESP;
                endcase
            end
            S_P1: begin o_cmd.act = mos_pkg::ACT_P1; n_state = S_P2; end
            S_P2: begin
                o_cmd.act = mos_pkg::ACT_P2;
                n_state   = (i_sts.dec.cls == mos_pkg::CL_JMPI) ? S_RESP : S_RDEA;
            end
            S_RDEA: begin
                o_cmd.act = mos_pkg::ACT_RDEA;
                if (mos_pkg::is_store(i_sts.dec.kind) || i_sts.dec.mode == mos_pkg::M_ACC)
                    n_state = S_RESP;
                else
                    n_state = S_DATA;
            end
            S_DATA: begin o_cmd.act = mos_pkg::ACT_DATA; n_state = S_RESP; end
            S_PLD:  begin o_cmd.act = mos_pkg::ACT_PLD;  n_state = S_RESP; end
            S_JSR2: begin o_cmd.act = mos_pkg::ACT_JSR2; n_state = S_RESP; end
            S_RTS1: begin o_cmd.act = mos_pkg::ACT_RTS1; n_state = S_RTS2; end
            S_RTS2: begin o_cmd.act = mos_pkg::ACT_RTS2; n_state = S_RESP; end
            S_RESP: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Hold state; reset restarts the memory clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("request taken while a result is pending");

    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_sts.clear_done) |=> (r_state == S_IDLE))
        else $error("clearing pass did not end");

    a_halt_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_operation == mos_pkg::HOP_EXEC
         && i_sts.halted) |=> (r_state == S_RESP))
        else $error("halted core started an instruction");

    a_rsp_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(i_out_ready))
        else $error("result dropped before it was taken");
`endif

endmodule

`default_nettype wire

// ===== hdl/mos_dp.sv =====
// Datapath of the 6502 executor: memory, architectural registers, address logic and ALU.
// Depends on mos_pkg; driven by step commands from mos_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mos_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mos_pkg::t_cmd              i_cmd,
    input  wire logic [15:0]                i_address,
    input  wire logic [7:0]                 i_write_data,
    input  wire logic [7:0]                 i_random_byte,
    input  wire logic                       i_cfg_we,
    input  wire logic [mos_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [15:0]                i_cfg_data,
    output mos_pkg::t_sts                   o_sts,
    output logic [1:0]                      o_status,
    output logic [7:0]                      o_read_data,
    output logic [7:0]                      o_accumulator,
    output logic [7:0]                      o_index_x,
    output logic [7:0]                      o_index_y,
    output logic [7:0]                      o_stack_pointer,
    output logic [15:0]                     o_program_counter,
    output logic [7:0]                      o_status_flags
);

    // Memory and its registered read port
    logic [7:0] r_mem [mos_pkg::MEM_BYTES];
    logic [7:0] r_rdata;
    logic [mos_pkg::MEM_AW-1:0] r_clr;

    // Architectural and working registers
    logic [15:0] r_start, r_rand;
    logic [7:0]  r_acc, r_x, r_y, r_sp, r_p;
    logic [15:0] r_pc;
    logic        r_err;
    logic [7:0]  r_opcode, r_b1, r_b2, r_ptr_lo, r_ptr_hi, r_read_data;
    logic [15:0] r_ptr_addr;

    mos_pkg::t_dec dec;
    logic        mem_we, mem_re;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wd;
    logic [15:0] ea, ptr_first, ptr_next, pc_step, br_target, ret_addr, ind_base;
    logic [15:0] stack_top, stack_up;
    logic [7:0]  store_val, push_val;
    logic        br_flag, rmw;

    // ALU and implied-op results
    logic [7:0]  alu_v, addend, ovf, cmp_reg;
    logic [8:0]  sum, diff;
    logic [7:0]  a_acc, a_x, a_y, a_p, a_res;
    logic [7:0]  m_acc, m_x, m_y, m_sp, m_p;

    function automatic logic [7:0] set_nz(input logic [7:0] f, input logic [7:0] v);
        logic [7:0] g;
        g = f;
        g[mos_pkg::F_N] = v[7];
        g[mos_pkg::F_Z] = (v == 8'h00);
        return g;
    endfunction

    assign dec = mos_pkg::decode(r_opcode);

    assign o_sts.dec        = dec;
    assign o_sts.halted     = r_err | r_p[mos_pkg::F_B];
    assign o_sts.clear_done = (r_clr == {mos_pkg::MEM_AW{1'b1}});

    // Address arithmetic
    always_comb begin
        ind_base  = {r_ptr_hi, r_ptr_lo};
        stack_top = {mos_pkg::STACK_PAGE, r_sp};
        stack_up  = {mos_pkg::STACK_PAGE, 8'(r_sp + 8'd1)};
        ret_addr  = r_pc + 16'd2;
        br_target = r_pc + 16'd2 + {{8{r_b1[7]}}, r_b1};
        unique case (dec.mode)
            mos_pkg::M_IMM:  ea = r_pc + 16'd1;
            mos_pkg::M_ZP:   ea = {8'h00, r_b1};
            mos_pkg::M_ZPX:  ea = {8'h00, 8'(r_b1 + r_x)};
            mos_pkg::M_ZPY:  ea = {8'h00, 8'(r_b1 + r_y)};
            mos_pkg::M_ABS:  ea = {r_b2, r_b1};
            mos_pkg::M_ABSX: ea = {r_b2, r_b1} + {8'h00, r_x};
            mos_pkg::M_ABSY: ea = {r_b2, r_b1} + {8'h00, r_y};
            mos_pkg::M_INDX: ea = ind_base;
            mos_pkg::M_INDY: ea = ind_base + {8'h00, r_y};
            default:         ea = 16'h0000;
        endcase
        if (dec.cls == mos_pkg::CL_JMPI)
            ptr_first = {r_b2, r_b1};
        else if (dec.mode == mos_pkg::M_INDX)
            ptr_first = {8'h00, 8'(r_b1 + r_x)};
        else
            ptr_first = {8'h00, r_b1};
        // pointer high byte: full wrap for JMP, page-zero wrap otherwise
        if (dec.cls == mos_pkg::CL_JMPI)
            ptr_next = r_ptr_addr + 16'd1;
        else
            ptr_next = {8'h00, 8'(r_ptr_addr[7:0] + 8'd1)};
        unique case (dec.mode)
            mos_pkg::M_IMP, mos_pkg::M_ACC:                 pc_step = r_pc + 16'd1;
            mos_pkg::M_ABS, mos_pkg::M_ABSX, mos_pkg::M_ABSY: pc_step = r_pc + 16'd3;
            default:                                        pc_step = r_pc + 16'd2;
        endcase
        unique case (r_opcode[7:6])
            2'd0:    br_flag = r_p[mos_pkg::F_N];
            2'd1:    br_flag = r_p[mos_pkg::F_V];
            2'd2:    br_flag = r_p[mos_pkg::F_C];
            default: br_flag = r_p[mos_pkg::F_Z];
        endcase
        unique case (dec.kind)
            mos_pkg::K_STX: store_val = r_x;
            mos_pkg::K_STY: store_val = r_y;
            default:        store_val = r_acc;
        endcase
        push_val = (r_opcode == mos_pkg::OP_PHA) ? r_acc : (r_p | mos_pkg::P_ONE);
        rmw = dec.kind inside {mos_pkg::K_ASL, mos_pkg::K_ROL, mos_pkg::K_LSR,
                               mos_pkg::K_ROR, mos_pkg::K_INC, mos_pkg::K_DEC};
    end

    // ALU for memory-operand instructions
    always_comb begin
        alu_v   = (dec.mode == mos_pkg::M_ACC) ? r_acc : r_rdata;
        addend  = (dec.kind == mos_pkg::K_SBC) ? ~alu_v : alu_v;
        sum     = {1'b0, r_acc} + {1'b0, addend} + {8'd0, r_p[mos_pkg::F_C]};
        ovf     = ~(r_acc ^ addend) & (r_acc ^ sum[7:0]);
        cmp_reg = (dec.kind == mos_pkg::K_CPX) ? r_x :
                  (dec.kind == mos_pkg::K_CPY) ? r_y : r_acc;
        diff    = {1'b0, cmp_reg} - {1'b0, alu_v};
        a_acc = r_acc;
        a_x   = r_x;
        a_y   = r_y;
        a_p   = r_p;
        a_res = alu_v;
        unique case (dec.kind) inside
            mos_pkg::K_ORA: begin a_acc = r_acc | alu_v; a_p = set_nz(r_p, a_acc); end
            mos_pkg::K_AND: begin a_acc = r_acc & alu_v; a_p = set_nz(r_p, a_acc); end
            mos_pkg::K_EOR: begin a_acc = r_acc ^ alu_v; a_p = set_nz(r_p, a_acc); end
            mos_pkg::K_ADC, mos_pkg::K_SBC: begin
                a_acc = sum[7:0];
                a_p   = set_nz(r_p, sum[7:0]);
                a_p[mos_pkg::F_V] = ovf[7];
                a_p[mos_pkg::F_C] = sum[8];
            end
            mos_pkg::K_LDA: begin a_acc = alu_v; a_p = set_nz(r_p, alu_v); end
            mos_pkg::K_LDX: begin a_x = alu_v; a_p = set_nz(r_p, alu_v); end
            mos_pkg::K_LDY: begin a_y = alu_v; a_p = set_nz(r_p, alu_v); end
            mos_pkg::K_CMP, mos_pkg::K_CPX, mos_pkg::K_CPY: begin
                a_p = set_nz(r_p, diff[7:0]);
                a_p[mos_pkg::F_C] = ~diff[8];
            end
            mos_pkg::K_BIT: begin
                a_p[mos_pkg::F_N] = alu_v[7];
                a_p[mos_pkg::F_V] = alu_v[6];
                a_p[mos_pkg::F_Z] = ((alu_v & r_acc) == 8'h00);
            end
            mos_pkg::K_ASL: begin
                a_res = {alu_v[6:0], 1'b0};
                a_p   = set_nz(r_p, a_res);
                a_p[mos_pkg::F_C] = alu_v[7];
            end
            mos_pkg::K_ROL: begin
                a_res = {alu_v[6:0], r_p[mos_pkg::F_C]};
                a_p   = set_nz(r_p, a_res);
                a_p[mos_pkg::F_C] = alu_v[7];
            end
            mos_pkg::K_LSR: begin
                a_res = {1'b0, alu_v[7:1]};
                a_p   = set_nz(r_p, a_res);
                a_p[mos_pkg::F_C] = alu_v[0];
            end
            mos_pkg::K_ROR: begin
                a_res = {r_p[mos_pkg::F_C], alu_v[7:1]};
                a_p   = set_nz(r_p, a_res);
                a_p[mos_pkg::F_C] = alu_v[0];
            end
            mos_pkg::K_INC: begin a_res = alu_v + 8'd1; a_p = set_nz(r_p, a_res); end
            mos_pkg::K_DEC: begin a_res = alu_v - 8'd1; a_p = set_nz(r_p, a_res); end
            default: ;
        endcase
        if (rmw && dec.mode == mos_pkg::M_ACC) a_acc = a_res;
    end

    // Single-byte register and flag instructions
    always_comb begin
        m_acc = r_acc;
        m_x   = r_x;
        m_y   = r_y;
        m_sp  = r_sp;
        m_p   = r_p;
        unique case (r_opcode) inside
            mos_pkg::OP_INX: begin m_x = r_x + 8'd1; m_p = set_nz(r_p, m_x); end
            mos_pkg::OP_INY: begin m_y = r_y + 8'd1; m_p = set_nz(r_p, m_y); end
            mos_pkg::OP_DEX: begin m_x = r_x - 8'd1; m_p = set_nz(r_p, m_x); end
            mos_pkg::OP_DEY: begin m_y = r_y - 8'd1; m_p = set_nz(r_p, m_y); end
            mos_pkg::OP_CLC: m_p[mos_pkg::F_C] = 1'b0;
            mos_pkg::OP_CLI: m_p[mos_pkg::F_I] = 1'b0;
            mos_pkg::OP_CLD: m_p[mos_pkg::F_D] = 1'b0;
            mos_pkg::OP_CLV: m_p[mos_pkg::F_V] = 1'b0;
            mos_pkg::OP_SEC: m_p[mos_pkg::F_C] = 1'b1;
            mos_pkg::OP_SEI: m_p[mos_pkg::F_I] = 1'b1;
            mos_pkg::OP_SED: m_p[mos_pkg::F_D] = 1'b1;
            mos_pkg::OP_TAX: begin m_x = r_acc; m_p = set_nz(r_p, r_acc); end
            mos_pkg::OP_TXA: begin m_acc = r_x; m_p = set_nz(r_p, r_x); end
            mos_pkg::OP_TAY: begin m_y = r_acc; m_p = set_nz(r_p, r_acc); end
            mos_pkg::OP_TYA: begin m_acc = r_y; m_p = set_nz(r_p, r_y); end
            mos_pkg::OP_TSX: begin m_x = r_sp; m_p = set_nz(r_p, r_sp); end
            mos_pkg::OP_TXS: m_sp = r_x;
            mos_pkg::OP_BRK: m_p[mos_pkg::F_B] = 1'b1;
            mos_pkg::OP_RTI: m_p[mos_pkg::F_B] = 1'b0;
            default: ;
        endcase
    end

    // Memory port: one access per step
    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = 16'h0000;
        mem_wd   = 8'h00;
        unique case (i_cmd.act)
            mos_pkg::ACT_CLEAR: begin
                mem_we = 1'b1;
                mem_addr[mos_pkg::MEM_AW-1:0] = r_clr;
            end
            mos_pkg::ACT_HOSTWR: begin
                mem_we = 1'b1; mem_addr = i_address; mem_wd = i_write_data;
            end
            mos_pkg::ACT_HOSTRD: begin mem_re = 1'b1; mem_addr = i_address; end
            mos_pkg::ACT_RANDWR: begin
                mem_we = 1'b1; mem_addr = r_rand; mem_wd = i_random_byte;
            end
            mos_pkg::ACT_F0: begin mem_re = 1'b1; mem_addr = r_pc; end
            mos_pkg::ACT_F1: begin mem_re = 1'b1; mem_addr = r_pc + 16'd1; end
            mos_pkg::ACT_F2: begin mem_re = 1'b1; mem_addr = r_pc + 16'd2; end
            mos_pkg::ACT_DEC: begin
                unique case (dec.cls)
                    mos_pkg::CL_JMPI: begin mem_re = 1'b1; mem_addr = ptr_first; end
                    mos_pkg::CL_MEM: begin
                        mem_re   = mos_pkg::is_ptr_mode(dec.mode);
                        mem_addr = ptr_first;
                    end
                    mos_pkg::CL_PUSH: begin
                        mem_we = 1'b1; mem_addr = stack_top; mem_wd = push_val;
                    end
                    mos_pkg::CL_JSR: begin
                        mem_we = 1'b1; mem_addr = stack_top; mem_wd = ret_addr[15:8];
                    end
                    mos_pkg::CL_PULL, mos_pkg::CL_RTS: begin
                        mem_re = 1'b1; mem_addr = stack_up;
                    end
                    default: ;
                endcase
            end
            mos_pkg::ACT_P1: begin mem_re = 1'b1; mem_addr = ptr_next; end
            mos_pkg::ACT_RDEA: begin
                mem_addr = ea;
                mem_wd   = store_val;
                if (mos_pkg::is_store(dec.kind))
                    mem_we = 1'b1;
                else
                    mem_re = (dec.mode != mos_pkg::M_ACC);
            end
            mos_pkg::ACT_DATA: begin
                mem_we = rmw; mem_addr = ea; mem_wd = a_res;
            end
            mos_pkg::ACT_JSR2: begin
                mem_we = 1'b1; mem_addr = stack_top; mem_wd = ret_addr[7:0];
            end
            mos_pkg::ACT_RTS1: begin mem_re = 1'b1; mem_addr = stack_up; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr[mos_pkg::MEM_AW-1:0]] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[mem_addr[mos_pkg::MEM_AW-1:0]];
    end

    // Working bytes of the current instruction
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.act)
            mos_pkg::ACT_F1:   r_opcode   <= r_rdata;
            mos_pkg::ACT_F2:   r_b1       <= r_rdata;
            mos_pkg::ACT_F3:   r_b2       <= r_rdata;
            mos_pkg::ACT_DEC:  r_ptr_addr <= ptr_first;
            mos_pkg::ACT_P1:   r_ptr_lo   <= r_rdata;
            mos_pkg::ACT_P2:   r_ptr_hi   <= r_rdata;
            mos_pkg::ACT_RTS1: r_ptr_lo   <= r_rdata;
            default: ;
        endcase
        if (i_cmd.accept) r_read_data <= 8'h00;
        if (i_cmd.act == mos_pkg::ACT_RDLAT) r_read_data <= r_rdata;
    end

    // Architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= mos_pkg::START_RST;
            r_rand  <= mos_pkg::RAND_RST;
            r_clr   <= '0;
            r_acc   <= 8'h00;
            r_x     <= 8'h00;
            r_y     <= 8'h00;
            r_sp    <= mos_pkg::SP_RST;
            r_pc    <= mos_pkg::START_RST;
            r_p     <= 8'h00;
            r_err   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mos_pkg::CFG_START) r_start <= i_cfg_data;
                if (i_cfg_index == mos_pkg::CFG_RAND)  r_rand  <= i_cfg_data;
            end
            unique case (i_cmd.act)
                mos_pkg::ACT_CLEAR: r_clr <= r_clr + 1'b1;
                mos_pkg::ACT_RESTART: begin
                    r_acc <= 8'h00;
                    r_x   <= 8'h00;
                    r_y   <= 8'h00;
                    r_sp  <= mos_pkg::SP_RST;
                    r_pc  <= r_start;
                    r_p   <= 8'h00;
                    r_err <= 1'b0;
                end
                mos_pkg::ACT_DEC: begin
                    unique case (dec.cls)
                        mos_pkg::CL_BAD: r_err <= 1'b1;
                        mos_pkg::CL_IMPL: begin
                            r_acc <= m_acc;
                            r_x   <= m_x;
                            r_y   <= m_y;
                            r_sp  <= m_sp;
                            r_p   <= m_p;
                            r_pc  <= r_pc + 16'd1;
                        end
                        mos_pkg::CL_BRANCH: begin
                            r_pc <= (br_flag == r_opcode[5]) ? br_target : ret_addr;
                        end
                        mos_pkg::CL_JMP: r_pc <= {r_b2, r_b1};
                        mos_pkg::CL_PUSH: begin
                            r_sp <= r_sp - 8'd1;
                            r_pc <= r_pc + 16'd1;
                        end
                        mos_pkg::CL_JSR: r_sp <= r_sp - 8'd1;
                        mos_pkg::CL_PULL, mos_pkg::CL_RTS: r_sp <= r_sp + 8'd1;
                        default: ;
                    endcase
                end
                mos_pkg::ACT_P2: begin
                    if (dec.cls == mos_pkg::CL_JMPI) r_pc <= {r_rdata, r_ptr_lo};
                end
                mos_pkg::ACT_RDEA: begin
                    if (mos_pkg::is_store(dec.kind)) begin
                        r_pc <= pc_step;
                    end else if (dec.mode == mos_pkg::M_ACC) begin
                        r_acc <= a_acc;
                        r_p   <= a_p;
                        r_pc  <= pc_step;
                    end
                end
                mos_pkg::ACT_DATA: begin
                    r_acc <= a_acc;
                    r_x   <= a_x;
                    r_y   <= a_y;
                    r_p   <= a_p;
                    r_pc  <= pc_step;
                end
                mos_pkg::ACT_PLD: begin
                    if (r_opcode == mos_pkg::OP_PLA) begin
                        r_acc <= r_rdata;
                        r_p   <= set_nz(r_p, r_rdata);
                    end else begin
                        r_p <= r_rdata & mos_pkg::P_PULL;
                    end
                    r_pc <= r_pc + 16'd1;
                end
                mos_pkg::ACT_JSR2: begin
                    r_sp <= r_sp - 8'd1;
                    r_pc <= {r_b2, r_b1};
                end
                mos_pkg::ACT_RTS1: r_sp <= r_sp + 8'd1;
                mos_pkg::ACT_RTS2: r_pc <= {r_rdata, r_ptr_lo} + 16'd1;
                default: ;
            endcase
        end
    end

    // Result snapshot
    assign o_status = r_err ? mos_pkg::ST_ERR :
                      (r_p[mos_pkg::F_B] ? mos_pkg::ST_BRK : mos_pkg::ST_RUN);
    assign o_read_data       = r_read_data;
    assign o_accumulator     = r_acc;
    assign o_index_x         = r_x;
    assign o_index_y         = r_y;
    assign o_stack_pointer   = r_sp;
    assign o_program_counter = r_pc;
    assign o_status_flags    = r_p | mos_pkg::P_ONE;

endmodule

`default_nettype wire

// ===== hdl/mos6502_instruction_executor_unit.sv =====
// Top level of the 6502 instruction executor: request/result channels and config port.
// Depends on mos_pkg, mos_req_if, mos_rsp_if, mos_ctrl and mos_dp.
`timescale 1ns / 1ps
`default_nettype none

// A 6502 core with 64 KiB of byte memory behind a single port. One request at a time:
// a memory write or a restart goes from idle straight to the result state, a memory
// read passes through a read-latch state first, and an execute fetches the opcode and
// two operand bytes, then does up to two pointer reads, one data read and a write-back,
// one memory access per cycle, or goes straight to the result when the core is already
// halted. The result stays on the result channel until taken; the next request is taken
// the cycle after. No request is taken while the memory is cleared to zero after reset;
// configuration writes are taken at any time and act at next restart or random-byte store.
module mos6502_instruction_executor_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    mos_req_if.sink                         i_req,
    mos_rsp_if.source                       o_rsp,
    input  wire logic                       i_cfg_we,
    input  wire logic [mos_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [15:0]                i_cfg_data
);

    mos_pkg::t_cmd cmd;
    mos_pkg::t_sts sts;

    // Sequencer
    mos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_operation (i_req.operation),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    // Memory, registers and ALU
    mos_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_address         (i_req.address),
        .i_write_data      (i_req.write_data),
        .i_random_byte     (i_req.random_byte),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_sts             (sts),
        .o_status          (o_rsp.status),
        .o_read_data       (o_rsp.read_data),
        .o_accumulator     (o_rsp.accumulator),
        .o_index_x         (o_rsp.index_x),
        .o_index_y         (o_rsp.index_y),
        .o_stack_pointer   (o_rsp.stack_pointer),
        .o_program_counter (o_rsp.program_counter),
        .o_status_flags    (o_rsp.status_flags)
    );

endmodule

`default_nettype wire
